// ===== hw/rtl/llas_pkg.sv =====
// Shared types and constants of the least-loaded application selector table.
`default_nettype none

package llas_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	// Command codes
	localparam logic [1:0] CMD_SYNC = 2'd0;
	localparam logic [1:0] CMD_DISC = 2'd1;
	localparam logic [1:0] CMD_SEL  = 2'd2;

	// Status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_REFUSED   = 2'd3;

	// One table entry as stored in the memory
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] type_mask;
		logic [15:0] online;
		logic [31:0] socket;
	} entry_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic scan;
		logic apply;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_done;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/llas_ctrl.sv =====
// Controller state machine: accept, scan the table, apply the command.
`default_nettype none

module llas_ctrl import llas_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd,
	output logic          busy
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/llas_dp.sv =====
// Datapath: entry memory, valid bits, scan evaluation and result registers.
`default_nettype none

module llas_dp import llas_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     ctl,
	output dp_stat_t         stat,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] app_id,
	input  wire logic [15:0] type_mask,
	input  wire logic [15:0] online,
	input  wire logic [31:0] socket,
	input  wire logic        endpoint_known,
	output logic             done,
	output logic [1:0]       status,
	output logic [15:0]      sel_id,
	output logic [15:0]      sel_type,
	output logic [15:0]      sel_online,
	output logic [31:0]      sel_socket
);

	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);

	// Entry storage
	entry_t                   mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	// Latched command
	logic [1:0]  cmd_q;
	logic [15:0] id_q;
	logic [15:0] ty_q;
	logic [15:0] on_q;
	logic [31:0] sk_q;
	logic        known_q;

	// Scan state
	logic [CNT_W-1:0] cnt_q;
	logic             rd_en;
	logic             rvld_s1;
	logic [IDX_W-1:0] ridx_s1;
	entry_t           rdata_s1;

	// Running selection
	logic             hit_q;
	entry_t           best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	logic   cand;
	logic   take_free;
	logic   cur_valid;

	// Apply results
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic             set_valid;
	logic             clr_valid;
	logic [1:0]       res_status;
	entry_t           res_entry;

	assign rd_en          = ctl.scan && (cnt_q < CNT_END);
	assign stat.scan_done = (cnt_q == CNT_END) && !rvld_s1;
	assign cur_valid      = valid_q[ridx_s1];

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[cnt_q[IDX_W-1:0]];
		end
	end

	// Scan address counter and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rvld_s1 <= 1'b0;
		end else if (ctl.load) begin
			cnt_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= rd_en;
			if (rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ridx_s1 <= cnt_q[IDX_W-1:0];
		end
	end

	// Input latch
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= command;
			id_q    <= app_id;
			ty_q    <= type_mask;
			on_q    <= online;
			sk_q    <= socket;
			known_q <= endpoint_known;
		end
	end

	// Candidate test for the entry read back this cycle
	always_comb begin
		cand      = 1'b0;
		take_free = 1'b0;
		if (rvld_s1) begin
			case (cmd_q)
				CMD_SYNC: begin
					cand      = cur_valid && (rdata_s1.id == id_q) && !hit_q;
					take_free = !cur_valid && !free_q;
				end
				CMD_DISC: begin
					cand = cur_valid && (rdata_s1.socket == sk_q) &&
					       (!hit_q || (rdata_s1.id < best_q.id));
				end
				CMD_SEL: begin
					cand = cur_valid && ((rdata_s1.type_mask & ty_q) != 16'd0) &&
					       (!hit_q || (rdata_s1.online < best_q.online) ||
					        ((rdata_s1.online == best_q.online) &&
					         (rdata_s1.id < best_q.id)));
				end
				default: begin
					cand = 1'b0;
				end
			endcase
		end
	end

	// Running best and first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.load) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (cand) begin
				hit_q <= 1'b1;
			end
			if (take_free) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cand) begin
			best_q     <= rdata_s1;
			best_idx_q <= ridx_s1;
		end
		if (take_free) begin
			free_idx_q <= ridx_s1;
		end
	end

	// Apply: table update and result
	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = best_idx_q;
		wr_data    = best_q;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		res_status = STAT_NOT_FOUND;
		res_entry  = '0;
		case (cmd_q)
			CMD_SYNC: begin
				if (hit_q) begin
					wr_data.online = on_q;
					wr_data.socket = sk_q;
					wr_en          = ctl.apply;
					res_status     = STAT_OK;
					res_entry      = wr_data;
				end else if (!known_q) begin
					res_status   = STAT_REFUSED;
					res_entry.id = id_q;
				end else if (!free_q) begin
					res_status   = STAT_FULL;
					res_entry.id = id_q;
				end else begin
					wr_addr    = free_idx_q;
					wr_data    = '{id: id_q, type_mask: ty_q, online: on_q, socket: sk_q};
					wr_en      = ctl.apply;
					set_valid  = ctl.apply;
					res_status = STAT_OK;
					res_entry  = wr_data;
				end
			end
			CMD_DISC: begin
				if (hit_q) begin
					clr_valid  = ctl.apply;
					res_status = STAT_OK;
					res_entry  = best_q;
				end
			end
			CMD_SEL: begin
				if (hit_q) begin
					if (best_q.online != 16'hFFFF) begin
						wr_data.online = best_q.online + 16'd1;
					end
					wr_en      = ctl.apply;
					res_status = STAT_OK;
					res_entry  = wr_data;
				end
			end
			default: begin
				res_status = STAT_NOT_FOUND;
			end
		endcase
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (set_valid) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[best_idx_q] <= 1'b0;
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl.apply;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			status     <= res_status;
			sel_id     <= res_entry.id;
			sel_type   <= res_entry.type_mask;
			sel_online <= res_entry.online;
			sel_socket <= res_entry.socket;
		end
	end

	// Checks
	a_done_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ctl.apply))
		else $error("result strobe without a preceding apply");

	a_no_load_in_apply: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.apply && ctl.load))
		else $error("new command loaded while applying");

	a_sel_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (cmd_q == CMD_SEL) && (status == STAT_OK)) |-> (sel_online != 16'd0))
		else $error("selected entry count not incremented");

	a_full_only_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STAT_FULL || status == STAT_REFUSED)) |-> (cmd_q == CMD_SYNC))
		else $error("full or refused status on a non-sync command");

endmodule

`default_nettype wire

// ===== hw/rtl/least_loaded_app_selector_table.sv =====
// Top level of the least-loaded application selector table.
//
// Command channel: present command and its fields with start high; the
// transfer takes place at a rising edge with start high and busy low.
// busy stays high until the command has been applied to the table.
// Result channel: done is high for exactly one cycle with status and the
// sel_* fields; the receiver cannot stall and takes the result that cycle.
// Every command, including the unused code, gives exactly one result.
// Each command scans all TABLE_ENTRIES slots through the single registered
// read port of the entry memory, one slot per cycle, then applies its
// update in the apply state. The result is registered, and a new command can
// be transferred in the cycle the result is shown.
// Reset (arst_n low) clears every valid bit at once, so the table is empty
// and ready on the first cycle after reset; entry contents are not cleared.
`default_nettype none

module least_loaded_app_selector_table import llas_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] app_id,
	input  wire logic [15:0] type_mask,
	input  wire logic [15:0] online,
	input  wire logic [31:0] socket,
	input  wire logic        endpoint_known,
	output logic             done,
	output logic [1:0]       status,
	output logic [15:0]      sel_id,
	output logic [15:0]      sel_type,
	output logic [15:0]      sel_online,
	output logic [31:0]      sel_socket
);

	dp_cmd_t  ctl;
	dp_stat_t stat;

	// Controller
	llas_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (ctl),
		.busy   (busy)
	);

	// Datapath
	llas_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.command        (command),
		.app_id         (app_id),
		.type_mask      (type_mask),
		.online         (online),
		.socket         (socket),
		.endpoint_known (endpoint_known),
		.done           (done),
		.status         (status),
		.sel_id         (sel_id),
		.sel_type       (sel_type),
		.sel_online     (sel_online),
		.sel_socket     (sel_socket)
	);

endmodule

`default_nettype wire

// ===== sim/llas_checker.sv =====
// Checker for the least-loaded application selector table: predicts each result and compares it.
`timescale 1ns / 1ps

module llas_checker import llas_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  command,
	input  logic [15:0] app_id,
	input  logic [15:0] type_mask,
	input  logic [15:0] online,
	input  logic [31:0] socket,
	input  logic        endpoint_known,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [15:0] sel_id,
	input  logic [15:0] sel_type,
	input  logic [15:0] sel_online,
	input  logic [31:0] sel_socket,
	output int          mismatch_count,
	output int          results_checked,
	output int          pending_results
);

	// One result as seen on the result ports; field order matches entry_t
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] id;
		logic [15:0] type_mask;
		logic [15:0] online;
		logic [31:0] socket;
	} table_result_t;

	// Shadow copy of the server table
	logic   slot_valid [TABLE_ENTRIES];
	entry_t slot_entry [TABLE_ENTRIES];

	// Results still owed by the block, oldest first
	table_result_t expected_results [$];

	initial begin
		mismatch_count  = 0;
		results_checked = 0;
		pending_results = 0;
	end

	// Print one line per mismatch and count it
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("[%0t] mismatch: %s got %0h expected %0h", $time, what, got, want);
	endtask

	// Apply one command to the shadow table and return the result it gives
	function automatic table_result_t predict_table_update(input logic [1:0] cmd,
			input logic [15:0] id, input logic [15:0] ty, input logic [15:0] on,
			input logic [31:0] sk, input logic known);
		table_result_t r;
		int hit;
		int free_slot;
		r = '0;
		r.status = STAT_NOT_FOUND;
		hit = -1;
		free_slot = -1;
		case (cmd)
			CMD_SYNC: begin
				for (int s = 0; s < TABLE_ENTRIES; s++) begin
					if (slot_valid[s] && slot_entry[s].id == id && hit < 0)
						hit = s;
					if (!slot_valid[s] && free_slot < 0)
						free_slot = s;
				end
				if (hit >= 0) begin
					// existing id: refresh count and handle, keep the type
					slot_entry[hit].online = on;
					slot_entry[hit].socket = sk;
					r = {STAT_OK, slot_entry[hit]};
				end else if (!known) begin
					r.status = STAT_REFUSED;
					r.id = id;
				end else if (free_slot < 0) begin
					r.status = STAT_FULL;
					r.id = id;
				end else begin
					slot_valid[free_slot] = 1'b1;
					slot_entry[free_slot] = '{id: id, type_mask: ty, online: on, socket: sk};
					r = {STAT_OK, slot_entry[free_slot]};
				end
			end
			CMD_DISC: begin
				// lowest id among entries holding this handle
				for (int s = 0; s < TABLE_ENTRIES; s++) begin
					if (slot_valid[s] && slot_entry[s].socket == sk &&
							(hit < 0 || slot_entry[s].id < slot_entry[hit].id))
						hit = s;
				end
				if (hit >= 0) begin
					r = {STAT_OK, slot_entry[hit]};
					slot_valid[hit] = 1'b0;
				end
			end
			CMD_SEL: begin
				// fewest online among entries sharing a type bit, ties to lowest id
				for (int s = 0; s < TABLE_ENTRIES; s++) begin
					if (slot_valid[s] && (slot_entry[s].type_mask & ty) != 16'h0000) begin
						if (hit < 0 || slot_entry[s].online < slot_entry[hit].online ||
								(slot_entry[s].online == slot_entry[hit].online &&
								slot_entry[s].id < slot_entry[hit].id))
							hit = s;
					end
				end
				if (hit >= 0) begin
					if (slot_entry[hit].online != 16'hFFFF)
						slot_entry[hit].online = slot_entry[hit].online + 16'd1;
					r = {STAT_OK, slot_entry[hit]};
				end
			end
			default: begin
				// unused code: not found, all fields zero
			end
		endcase
		return r;
	endfunction

	// Retire results, then predict a newly transferred command
	always @(posedge clk or negedge arst_n) begin
		table_result_t got;
		table_result_t want;
		if (!arst_n) begin
			for (int s = 0; s < TABLE_ENTRIES; s++)
				slot_valid[s] = 1'b0;
			expected_results.delete();
			pending_results <= 0;
		end else begin
			if (done) begin
				got = {status, sel_id, sel_type, sel_online, sel_socket};
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing outstanding, status",
						32'(got.status), '0);
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (got.status !== want.status)
						report_mismatch("status", 32'(got.status), 32'(want.status));
					if (got.id !== want.id)
						report_mismatch("sel_id", 32'(got.id), 32'(want.id));
					if (got.type_mask !== want.type_mask)
						report_mismatch("sel_type", 32'(got.type_mask), 32'(want.type_mask));
					if (got.online !== want.online)
						report_mismatch("sel_online", 32'(got.online), 32'(want.online));
					if (got.socket !== want.socket)
						report_mismatch("sel_socket", got.socket, want.socket);
				end
			end
			if (start && !busy) begin
				expected_results.push_back(predict_table_update(command, app_id, type_mask,
					online, socket, endpoint_known));
			end
			pending_results <= expected_results.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Top of the selector table testbench: clock, reset, command stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
	import llas_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 625;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  command = CMD_SYNC;
	logic [15:0] app_id = '0;
	logic [15:0] type_mask = '0;
	logic [15:0] online = '0;
	logic [31:0] socket = '0;
	logic        endpoint_known = 1'b0;
	logic        done;
	logic [1:0]  status;
	logic [15:0] sel_id;
	logic [15:0] sel_type;
	logic [15:0] sel_online;
	logic [31:0] sel_socket;

	int mismatches;
	int results_checked;
	int pending;
	int idle_pct = 0;
	int stall_cycles = 0;
	int cmd_counts [4] = '{default: 0};
	logic [15:0] id_pool [24];
	logic [31:0] sock_pool [8];

	least_loaded_app_selector_table i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.app_id         (app_id),
		.type_mask      (type_mask),
		.online         (online),
		.socket         (socket),
		.endpoint_known (endpoint_known),
		.done           (done),
		.status         (status),
		.sel_id         (sel_id),
		.sel_type       (sel_type),
		.sel_online     (sel_online),
		.sel_socket     (sel_socket)
	);

	llas_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.app_id          (app_id),
		.type_mask       (type_mask),
		.online          (online),
		.socket          (socket),
		.endpoint_known  (endpoint_known),
		.done            (done),
		.status          (status),
		.sel_id          (sel_id),
		.sel_type        (sel_type),
		.sel_online      (sel_online),
		.sel_socket      (sel_socket),
		.mismatch_count  (mismatches),
		.results_checked (results_checked),
		.pending_results (pending)
	);

	always #6 clk = ~clk;

	// Watchdog: give up after a long stretch with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Random sender gap, then present one command and hold it until transfer
	task automatic send_command(input logic [1:0] cmd, input logic [15:0] id,
			input logic [15:0] ty, input logic [15:0] on, input logic [31:0] sk,
			input logic known);
		int extra;
		extra = (idle_pct > 0 && $urandom_range(0, 99) < 5) ? $urandom_range(1, 30) : 0;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		repeat (extra) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		app_id <= id;
		type_mask <= ty;
		online <= on;
		socket <= sk;
		endpoint_known <= known;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		cmd_counts[cmd]++;
	endtask

	// Mostly pooled ids and handles so hits, ties and a full table occur; some pure noise
	task automatic send_random_item();
		logic [1:0]  cmd;
		logic [15:0] id;
		logic [15:0] ty;
		logic [15:0] on;
		logic [31:0] sk;
		logic        known;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			cmd = 2'($urandom_range(0, 3));
			id = 16'($urandom);
			ty = 16'($urandom);
			on = 16'($urandom);
			sk = $urandom;
			known = 1'($urandom_range(0, 1));
		end else begin
			id = id_pool[$urandom_range(0, 23)];
			sk = sock_pool[$urandom_range(0, 7)];
			known = ($urandom_range(0, 99) < 85);
			case ($urandom_range(0, 19))
				0: ty = 16'h0000;
				1: ty = 16'($urandom);
				2: ty = 16'h1 << $urandom_range(0, 15);
				default: ty = (16'h1 << $urandom_range(0, 5)) | (16'h1 << $urandom_range(0, 5));
			endcase
			pick = $urandom_range(0, 9);
			if (pick < 5)
				on = 16'($urandom_range(0, 3));
			else if (pick < 7)
				on = 16'hFFFF - 16'($urandom_range(0, 2));
			else
				on = 16'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 42)
				cmd = CMD_SYNC;
			else if (pick < 64)
				cmd = CMD_DISC;
			else if (pick < 97)
				cmd = CMD_SEL;
			else
				cmd = CMD_UNUSED;
		end
		send_command(cmd, id, ty, on, sk, known);
	endtask

	// Stop sending and wait until every outstanding result has come back
	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		logic [15:0] fill_id;
		int phase_idle [3];
		phase_idle = '{32, 73, 0};
		foreach (id_pool[i])
			id_pool[i] = 16'($urandom);
		foreach (sock_pool[i])
			sock_pool[i] = $urandom;
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		sock_pool[0] = 32'h0000_0000;
		sock_pool[1] = 32'hFFFF_FFFF;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, unused code, refusal, extremes, saturation, ties, full table
		idle_pct = 32;
		send_command(CMD_SEL, 16'h0000, 16'hFFFF, 16'h0000, 32'h0, 1'b1);
		send_command(CMD_DISC, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b1);
		send_command(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		send_command(CMD_SYNC, 16'h1234, 16'h00F0, 16'h0005, 32'h0000_00A5, 1'b0);
		send_command(CMD_SYNC, 16'h0000, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		send_command(CMD_SYNC, 16'hFFFF, 16'h0001, 16'h0000, 32'h0000_0000, 1'b1);
		send_command(CMD_SEL, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b1);
		send_command(CMD_SEL, 16'h0000, 16'h8000, 16'h0000, 32'h0, 1'b1);
		send_command(CMD_SEL, 16'h0000, 16'h0001, 16'h0000, 32'h0, 1'b1);
		send_command(CMD_SYNC, 16'hFFFF, 16'hFF00, 16'hFFFF, 32'h0000_0001, 1'b0);
		send_command(CMD_SEL, 16'h0000, 16'h0001, 16'h0000, 32'h0, 1'b1);
		send_command(CMD_DISC, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b1);
		// fill with descending ids so the lowest id sits in the highest slot
		for (int i = 1; i <= 15; i++) begin
			fill_id = 16'hF000 - 16'(i * 256);
			send_command(CMD_SYNC, fill_id, 16'h0002, 16'h0007, 32'h5A5A_0005, 1'b1);
		end
		send_command(CMD_SEL, 16'h0000, 16'h0002, 16'h0000, 32'h0, 1'b1);
		send_command(CMD_SYNC, 16'h0042, 16'h0002, 16'h0001, 32'h0000_0042, 1'b1);
		send_command(CMD_DISC, 16'h0000, 16'h0000, 16'h0000, 32'h5A5A_0005, 1'b1);
		drain_results();

		// Random phases with different sender idling, fully drained in between
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = phase_idle[phase];
			repeat (PHASE_ITEMS)
				send_random_item();
			drain_results();
		end

		repeat (2 * (TABLE_ENTRIES + 4)) @(posedge clk);

		$display("covered %0d sync, %0d disconnect, %0d select and %0d unused-code commands",
			cmd_counts[CMD_SYNC], cmd_counts[CMD_DISC], cmd_counts[CMD_SEL],
			cmd_counts[CMD_UNUSED]);
		$display("%0d results compared, %0d mismatches; sender idling 32, 73 and 0 percent",
			results_checked, mismatches);
		if (mismatches == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
